// File: rtl/tdpt_pkg.sv
package tdpt_pkg;

  localparam int MAX_PERIODS  = 7;
  localparam int SECS_PER_DAY = 86400;

  // 86400 = 2^7 * 675: shift off the low seven bits, divide the rest by 675
  localparam int DAY_LOW_BITS = 7;
  localparam int DIV_ODD      = 675;
  // floor(2^33 / 675); quotient estimate is exact or one low for 33-bit dividends
  localparam int RECIP        = 12725829;

  localparam int TIME_W  = 40;
  localparam int DAY_W   = 24;
  localparam int SECS_W  = 17;
  localparam int START_W = 17;
  localparam int PIDX_W  = 3;
  localparam int BASE_W  = 41;
  localparam int STIME_W = 42;
  localparam int ETIME_W = 41;
  localparam int REM_W   = 11;

  typedef logic [START_W-1:0]                 start_t;
  typedef start_t [MAX_PERIODS-1:0]           starts_t;

  typedef enum logic [2:0] {
    REG_NUM_PERIODS = 3'd0,
    REG_START_0     = 3'd1,
    REG_START_1     = 3'd2,
    REG_START_2     = 3'd3,
    REG_START_3     = 3'd4,
    REG_START_4     = 3'd5,
    REG_START_5     = 3'd6,
    REG_START_6     = 3'd7
  } reg_idx_t;

  // active period table handed to the locate pipeline
  typedef struct packed {
    logic [PIDX_W-1:0] count;
    starts_t           starts;
  } period_cfg_t;

endpackage

// File: rtl/tdpt_daysplit.sv
module tdpt_daysplit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               i_valid,
  output logic                               i_ready,
  input  logic [tdpt_pkg::TIME_W-1:0]        i_t,
  output logic                               o_valid,
  input  logic                               o_ready,
  output logic [tdpt_pkg::TIME_W-1:0]        o_t,
  output logic [tdpt_pkg::DAY_W-1:0]         o_day,
  output logic [tdpt_pkg::SECS_W-1:0]        o_secs
);

  logic [4:0] vld_r;
  logic [4:0] adv;

  logic [tdpt_pkg::TIME_W-1:0] t0_r, t1_r, t2_r, t3_r, t4_r;
  logic [39:0]                 ph_r, ph_nxt;
  logic [40:0]                 pl_r, pl_nxt;
  logic [56:0]                 sum_nxt;
  logic [tdpt_pkg::DAY_W-1:0]  q2_r, q2_nxt, q3_r, day_r, day_nxt;
  logic [33:0]                 prod_nxt, diff_nxt;
  logic [tdpt_pkg::REM_W-1:0]  rem_r, rem_fix;
  logic [tdpt_pkg::SECS_W-1:0] secs_r, secs_nxt;

  // a stage takes new data when it is empty or its successor moves on
  always_comb begin
    adv[4] = !vld_r[4] || o_ready;
    adv[3] = !vld_r[3] || adv[4];
    adv[2] = !vld_r[2] || adv[3];
    adv[1] = !vld_r[1] || adv[2];
    adv[0] = !vld_r[0] || adv[1];
  end

  assign i_ready = adv[0];
  assign o_valid = vld_r[4];

  // partial products of (t >> 7) * RECIP, split at bit 17 of the dividend
  assign ph_nxt = {24'd0, t0_r[39:24]} * 40'(tdpt_pkg::RECIP);
  assign pl_nxt = {24'd0, t0_r[23:7]}  * 41'(tdpt_pkg::RECIP);

  assign sum_nxt = {ph_r, 17'd0} + {16'd0, pl_r};
  assign q2_nxt  = sum_nxt[56:33];

  assign prod_nxt = {10'd0, q2_r} * 34'(tdpt_pkg::DIV_ODD);
  assign diff_nxt = {1'b0, t2_r[39:7]} - prod_nxt;

  // estimate may be one low: fold the remainder back once
  always_comb begin
    if (rem_r >= tdpt_pkg::REM_W'(tdpt_pkg::DIV_ODD)) begin
      rem_fix = rem_r - tdpt_pkg::REM_W'(tdpt_pkg::DIV_ODD);
      day_nxt = q3_r + tdpt_pkg::DAY_W'(1);
    end else begin
      rem_fix = rem_r;
      day_nxt = q3_r;
    end
    secs_nxt = {rem_fix[9:0], t3_r[6:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= i_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
      if (adv[3]) vld_r[3] <= vld_r[2];
      if (adv[4]) vld_r[4] <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t0_r <= i_t;
    end
    if (adv[1]) begin
      t1_r <= t0_r;
      ph_r <= ph_nxt;
      pl_r <= pl_nxt;
    end
    if (adv[2]) begin
      t2_r <= t1_r;
      q2_r <= q2_nxt;
    end
    if (adv[3]) begin
      t3_r  <= t2_r;
      q3_r  <= q2_r;
      rem_r <= diff_nxt[10:0];
    end
    if (adv[4]) begin
      t4_r   <= t3_r;
      day_r  <= day_nxt;
      secs_r <= secs_nxt;
    end
  end

  assign o_t    = t4_r;
  assign o_day  = day_r;
  assign o_secs = secs_r;

endmodule

// File: rtl/tdpt_locate.sv
module tdpt_locate (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tdpt_pkg::period_cfg_t              cfg,
  input  logic                               i_valid,
  output logic                               i_ready,
  input  logic [tdpt_pkg::TIME_W-1:0]        i_t,
  input  logic [tdpt_pkg::DAY_W-1:0]         i_day,
  input  logic [tdpt_pkg::SECS_W-1:0]        i_secs,
  output logic                               o_valid,
  input  logic                               o_ready,
  output logic [tdpt_pkg::TIME_W-1:0]        o_t,
  output logic [tdpt_pkg::PIDX_W-1:0]        o_idx,
  output logic                               o_err,
  output logic [tdpt_pkg::STIME_W-1:0]       o_start,
  output logic [tdpt_pkg::STIME_W-1:0]       o_end
);

  logic [2:0] vld_r;
  logic [2:0] adv;

  logic [tdpt_pkg::TIME_W-1:0]  t0_r, t1_r, t2_r;
  logic [tdpt_pkg::PIDX_W-1:0]  p0_r, p1_r, p2_r, p_nxt, n0_r, nidx_nxt;
  logic                         err0_r, err1_r, err2_r, err_nxt, last0_r, last_nxt;
  logic [tdpt_pkg::BASE_W-1:0]  base0_r, base_nxt;
  logic [tdpt_pkg::STIME_W-1:0] s1_r, e1_r, s_raw, e_raw, e_wrap;
  logic [tdpt_pkg::STIME_W-1:0] s2_r, e2_r, s_adj, e_adj, tt42;

  always_comb begin
    adv[2] = !vld_r[2] || o_ready;
    adv[1] = !vld_r[1] || adv[2];
    adv[0] = !vld_r[0] || adv[1];
  end

  assign i_ready = adv[0];
  assign o_valid = vld_r[2];

  // period search: lowest matching slot wins, otherwise the wrapping last period
  always_comb begin
    p_nxt   = cfg.count - tdpt_pkg::PIDX_W'(1);
    err_nxt = 1'b0;
    for (int i = tdpt_pkg::MAX_PERIODS - 2; i >= 0; i--) begin
      if (i + 1 < int'(cfg.count)) begin
        if (cfg.starts[i] > cfg.starts[i+1]) err_nxt = 1'b1;
        if (i_secs > cfg.starts[i] && i_secs <= cfg.starts[i+1]) p_nxt = tdpt_pkg::PIDX_W'(i);
      end
    end
    last_nxt = (p_nxt == cfg.count - tdpt_pkg::PIDX_W'(1));
    nidx_nxt = last_nxt ? '0 : p_nxt + tdpt_pkg::PIDX_W'(1);
  end

  assign base_nxt = {17'd0, i_day} * tdpt_pkg::BASE_W'(tdpt_pkg::SECS_PER_DAY);

  // last period ends at the first start of the following day
  assign e_wrap = last0_r ? tdpt_pkg::STIME_W'(tdpt_pkg::SECS_PER_DAY) : '0;
  assign s_raw  = {1'b0, base0_r} + tdpt_pkg::STIME_W'(cfg.starts[p0_r]);
  assign e_raw  = {1'b0, base0_r} + tdpt_pkg::STIME_W'(cfg.starts[n0_r]) + e_wrap;

  assign tt42 = {2'b00, t1_r};

  // shift the bracket a day back or forward so that it holds the time
  always_comb begin
    if ($signed(s1_r) > $signed(tt42)) begin
      s_adj = s1_r - tdpt_pkg::STIME_W'(tdpt_pkg::SECS_PER_DAY);
      e_adj = e1_r - tdpt_pkg::STIME_W'(tdpt_pkg::SECS_PER_DAY);
    end else if ($signed(e1_r) < $signed(tt42)) begin
      s_adj = s1_r + tdpt_pkg::STIME_W'(tdpt_pkg::SECS_PER_DAY);
      e_adj = e1_r + tdpt_pkg::STIME_W'(tdpt_pkg::SECS_PER_DAY);
    end else begin
      s_adj = s1_r;
      e_adj = e1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= i_valid;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      t0_r    <= i_t;
      p0_r    <= p_nxt;
      n0_r    <= nidx_nxt;
      last0_r <= last_nxt;
      err0_r  <= err_nxt;
      base0_r <= base_nxt;
    end
    if (adv[1]) begin
      t1_r   <= t0_r;
      p1_r   <= p0_r;
      err1_r <= err0_r;
      s1_r   <= s_raw;
      e1_r   <= e_raw;
    end
    if (adv[2]) begin
      t2_r   <= t1_r;
      p2_r   <= p1_r;
      err2_r <= err1_r;
      s2_r   <= s_adj;
      e2_r   <= e_adj;
    end
  end

  assign o_t     = t2_r;
  assign o_idx   = p2_r;
  assign o_err   = err2_r;
  assign o_start = s2_r;
  assign o_end   = e2_r;

endmodule

// File: rtl/time_of_day_period_tracker.sv
// Time-of-day period tracker. Each transfer on the in_ stream carries an absolute
// time in seconds; one result per item leaves on the out_ stream, in order. The
// block takes one item per clock. An item passes nine register stages: five split
// the time into day and second-of-day by a reciprocal multiply, three find the
// period and its absolute bracket, and one compares against the stored period and
// updates it. Back-pressure on the output stalls the input only once every stage
// holds an item. Write the period count and start seconds through the cfg_ port
// while no item is in flight.
module time_of_day_period_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [39:0]                         in_tdata,   // [39:0] abs_time
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] changed, [3:1] period_index, [45:4] period_start, [86:46] period_end,
  // [87] config_error
  output logic [87:0]                         out_tdata,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [tdpt_pkg::START_W-1:0]        cfg_wdata
);

  logic [tdpt_pkg::PIDX_W-1:0] num_r;
  tdpt_pkg::starts_t           starts_r;
  tdpt_pkg::period_cfg_t       pcfg;

  logic                          ds_valid, ds_ready;
  logic [tdpt_pkg::TIME_W-1:0]   ds_t;
  logic [tdpt_pkg::DAY_W-1:0]    ds_day;
  logic [tdpt_pkg::SECS_W-1:0]   ds_secs;

  logic                          lc_valid, lc_ready, lc_err;
  logic [tdpt_pkg::TIME_W-1:0]   lc_t;
  logic [tdpt_pkg::PIDX_W-1:0]   lc_idx;
  logic [tdpt_pkg::STIME_W-1:0]  lc_start, lc_end;

  logic                          valid_r;
  logic [tdpt_pkg::PIDX_W-1:0]   cur_r;
  logic [tdpt_pkg::STIME_W-1:0]  pst_r, pend_r;
  logic                          out_tvalid_r;
  logic [87:0]                   out_data_r, out_data_nxt;
  logic                          fire, chg_nxt;
  logic [tdpt_pkg::PIDX_W-1:0]   idx_nxt;
  logic [tdpt_pkg::STIME_W-1:0]  pst_nxt, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r    <= tdpt_pkg::PIDX_W'(1);
      starts_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == tdpt_pkg::REG_NUM_PERIODS) begin
        num_r <= cfg_wdata[2:0];
      end else begin
        starts_r[cfg_index - 3'd1] <= cfg_wdata;
      end
    end
  end

  // a count of zero means one period
  always_comb begin
    pcfg.count  = (num_r == '0) ? tdpt_pkg::PIDX_W'(1) : num_r;
    pcfg.starts = starts_r;
  end

  tdpt_daysplit u_split (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (in_tvalid),
    .i_ready (in_tready),
    .i_t     (in_tdata),
    .o_valid (ds_valid),
    .o_ready (ds_ready),
    .o_t     (ds_t),
    .o_day   (ds_day),
    .o_secs  (ds_secs)
  );

  tdpt_locate u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (pcfg),
    .i_valid (ds_valid),
    .i_ready (ds_ready),
    .i_t     (ds_t),
    .i_day   (ds_day),
    .i_secs  (ds_secs),
    .o_valid (lc_valid),
    .o_ready (lc_ready),
    .o_t     (lc_t),
    .o_idx   (lc_idx),
    .o_err   (lc_err),
    .o_start (lc_start),
    .o_end   (lc_end)
  );

  assign lc_ready = !out_tvalid_r || out_tready;
  assign fire     = lc_valid && lc_ready;

  // report a change on a first item, new index or time past stored end, not on error
  always_comb begin
    chg_nxt = !lc_err && (!valid_r || lc_idx != cur_r ||
                          $signed({2'b00, lc_t}) > $signed(pend_r));
    idx_nxt  = chg_nxt ? lc_idx   : cur_r;
    pst_nxt  = chg_nxt ? lc_start : pst_r;
    pend_nxt = chg_nxt ? lc_end   : pend_r;
    out_data_nxt = {lc_err, pend_nxt[tdpt_pkg::ETIME_W-1:0], pst_nxt, idx_nxt, chg_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      cur_r        <= '0;
      pst_r        <= '0;
      pend_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (fire) begin
        out_tvalid_r <= 1'b1;
        if (chg_nxt) begin
          valid_r <= 1'b1;
          cur_r   <= lc_idx;
          pst_r   <= lc_start;
          pend_r  <= lc_end;
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_data_r[87] |-> !out_data_r[0])
    else $error("configuration error reported together with a change");

  a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(valid_r))
    else $error("stored period lost its valid flag");

  a_first_change: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_r) |-> out_tvalid_r && out_data_r[0])
    else $error("first stored period not reported as a change");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid_r |-> in_tready)
    else $error("input stalled while output register is empty");
`endif

endmodule

// File: tb/sv/tb_top.sv
module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_ITEMS   = 140;
  localparam int HOLD_CYCLES   = 64;
  localparam longint TIME_MASK = 64'hFF_FFFF_FFFF;

  // packed to match out_tdata, changed in bit 0
  typedef struct packed {
    logic                          config_error;
    logic [tdpt_pkg::ETIME_W-1:0]  period_end;
    logic [tdpt_pkg::STIME_W-1:0]  period_start;
    logic [tdpt_pkg::PIDX_W-1:0]   period_index;
    logic                          changed;
  } tod_result_t;

  typedef enum {ROW_TABLE, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [tdpt_pkg::TIME_W-1:0]  stamp;
    bit                           typed;
    tod_result_t                  want;
    logic [2:0]                   count;
    tdpt_pkg::starts_t            starts;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [39:0]                   in_tdata;    // [39:0] abs_time
  logic                          out_tvalid;
  logic                          out_tready;
  // [0] changed, [3:1] period_index, [45:4] period_start, [86:46] period_end,
  // [87] config_error
  logic [87:0]                   out_tdata;
  logic                          cfg_we;
  logic [2:0]                    cfg_index;
  logic [tdpt_pkg::START_W-1:0]  cfg_wdata;

  time_of_day_period_tracker u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // tracker copy: table as written through cfg_, period state as last updated
  logic [2:0]                   model_count;
  tdpt_pkg::starts_t            model_starts;
  bit                           have_period;
  logic [tdpt_pkg::PIDX_W-1:0]  cur_period;
  longint                       period_open;
  longint                       period_close;

  tod_result_t        pending_periods[$];
  stim_row_t          plan[$];

  bit                 in_took;
  bit                 out_took;
  bit                 want_typed;
  tod_result_t        typed_want;
  bit                 idle_on;
  longint             cursor;

  int                 items_taken;
  int                 results_checked;
  int                 change_count;
  int                 unordered_count;
  int                 table_loads;
  int                 mismatch_count;

  tod_result_t        exp_r;
  tod_result_t        got_r;

  function automatic tod_result_t track_period(input logic [tdpt_pkg::TIME_W-1:0] stamp);
    tod_result_t r;
    int          n;
    int          p;
    bit          found;
    bit          bad;
    longint      tt;
    longint      secs;
    longint      day;
    longint      base;
    longint      s;
    longint      e;
    n = (model_count == 0) ? 1 : int'(model_count);
    if (n > tdpt_pkg::MAX_PERIODS) n = tdpt_pkg::MAX_PERIODS;
    tt = longint'({24'b0, stamp});
    secs = tt % tdpt_pkg::SECS_PER_DAY;
    day = tt / tdpt_pkg::SECS_PER_DAY;
    bad = 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      if (model_starts[i] > model_starts[i+1]) bad = 1'b1;
    end
    r.changed = 1'b0;
    if (!bad) begin
      p = n - 1;
      found = 1'b0;
      for (int i = 0; i + 1 < n; i++) begin
        if (!found && secs > model_starts[i] && secs <= model_starts[i+1]) begin
          p = i;
          found = 1'b1;
        end
      end
      if (!have_period || p != int'(cur_period) || tt > period_close) begin
        base = day * tdpt_pkg::SECS_PER_DAY;
        s = base + longint'(model_starts[p]);
        if (p + 1 < n) e = base + longint'(model_starts[p+1]);
        else e = base + tdpt_pkg::SECS_PER_DAY + longint'(model_starts[0]);
        // shift the bracket by a day so that it holds the time
        if (s > tt) begin
          s -= tdpt_pkg::SECS_PER_DAY;
          e -= tdpt_pkg::SECS_PER_DAY;
        end else if (e < tt) begin
          s += tdpt_pkg::SECS_PER_DAY;
          e += tdpt_pkg::SECS_PER_DAY;
        end
        r.changed = 1'b1;
        have_period = 1'b1;
        cur_period = tdpt_pkg::PIDX_W'(p);
        period_open = s;
        period_close = e;
      end
    end
    r.period_index = cur_period;
    r.period_start = period_open[tdpt_pkg::STIME_W-1:0];
    r.period_end = period_close[tdpt_pkg::ETIME_W-1:0];
    r.config_error = bad;
    return r;
  endfunction

  function automatic stim_row_t table_row(input int count, input int s0, input int s1,
                                          input int s2, input int s3, input int s4,
                                          input int s5, input int s6);
    stim_row_t row;
    row.kind = ROW_TABLE;
    row.stamp = '0;
    row.typed = 1'b0;
    row.want = '0;
    row.count = 3'(count);
    row.starts[0] = tdpt_pkg::START_W'(s0);
    row.starts[1] = tdpt_pkg::START_W'(s1);
    row.starts[2] = tdpt_pkg::START_W'(s2);
    row.starts[3] = tdpt_pkg::START_W'(s3);
    row.starts[4] = tdpt_pkg::START_W'(s4);
    row.starts[5] = tdpt_pkg::START_W'(s5);
    row.starts[6] = tdpt_pkg::START_W'(s6);
    return row;
  endfunction

  function automatic stim_row_t time_row(input logic [tdpt_pkg::TIME_W-1:0] stamp);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.stamp = stamp;
    row.typed = 1'b0;
    row.want = '0;
    row.count = '0;
    row.starts = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [tdpt_pkg::TIME_W-1:0] stamp,
                                          input bit chg, input int idx,
                                          input longint open_s, input longint close_s,
                                          input bit err);
    stim_row_t row;
    row = time_row(stamp);
    row.typed = 1'b1;
    row.want.changed = chg;
    row.want.period_index = tdpt_pkg::PIDX_W'(idx);
    row.want.period_start = open_s[tdpt_pkg::STIME_W-1:0];
    row.want.period_end = close_s[tdpt_pkg::ETIME_W-1:0];
    row.want.config_error = err;
    return row;
  endfunction

  function automatic logic [tdpt_pkg::TIME_W-1:0] next_time();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n = (model_count == 0) ? 1 : int'(model_count);
    if (pick < 55) begin
      cursor += $urandom_range(0, 7200);
    end else if (pick < 70) begin
      // land on or next to a period boundary
      cursor = (cursor / tdpt_pkg::SECS_PER_DAY) * tdpt_pkg::SECS_PER_DAY
             + longint'(model_starts[$urandom_range(0, n - 1)])
             + longint'(int'($urandom_range(0, 2)) - 1);
    end else if (pick < 80) begin
      cursor += $urandom_range(tdpt_pkg::SECS_PER_DAY, 3 * tdpt_pkg::SECS_PER_DAY);
    end else if (pick < 88) begin
      cursor -= $urandom_range(0, tdpt_pkg::SECS_PER_DAY);
    end else if (pick < 96) begin
      cursor = {$urandom, $urandom};
    end else begin
      cursor = TIME_MASK - $urandom_range(0, 200000);
    end
    cursor &= TIME_MASK;
    return cursor[tdpt_pkg::TIME_W-1:0];
  endfunction

  task automatic write_reg(input logic [2:0] idx,
                           input logic [tdpt_pkg::START_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic load_table(input logic [2:0] count, input tdpt_pkg::starts_t starts);
    // drain every result before touching the table
    in_tvalid <= 1'b0;
    while (pending_periods.size() != 0) @(negedge clk);
    write_reg(tdpt_pkg::REG_NUM_PERIODS, {{(tdpt_pkg::START_W-3){1'b0}}, count});
    for (int k = 0; k < tdpt_pkg::MAX_PERIODS; k++) begin
      write_reg(3'(tdpt_pkg::REG_START_0 + k), starts[k]);
    end
    cfg_we <= 1'b0;
    table_loads++;
  endtask

  task automatic offer_time(input logic [tdpt_pkg::TIME_W-1:0] stamp, input bit typed,
                            input tod_result_t want);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= stamp;
    want_typed = typed;
    typed_want = want;
    do @(negedge clk); while (!in_took);
  endtask

  task automatic load_random_table(input int phase);
    logic [2:0]        count;
    tdpt_pkg::starts_t starts;
    int                v[tdpt_pkg::MAX_PERIODS];
    int                shape;
    int                j;
    int                n;
    for (int k = 0; k < tdpt_pkg::MAX_PERIODS; k++) begin
      v[k] = $urandom_range(0, tdpt_pkg::SECS_PER_DAY - 1);
    end
    v.sort();
    n = $urandom_range(1, tdpt_pkg::MAX_PERIODS);
    shape = (phase == 2) ? 2 : $urandom_range(0, 9);
    if (phase == 0) begin
      n = tdpt_pkg::MAX_PERIODS;
      v = '{0, 1, 14400, 43200, 43200, 86398, 86399};
    end else if (phase == 1) begin
      n = 1;
    end else if (shape < 2 && n > 1) begin
      j = $urandom_range(0, n - 2);
      v[j+1] = v[j];
    end else if (shape == 2) begin
      v[n-1] = $urandom_range(tdpt_pkg::SECS_PER_DAY, 131071);
    end else if (shape == 3) begin
      // crowd the starts into a narrow window
      v[0] = $urandom_range(0, tdpt_pkg::SECS_PER_DAY - 200);
      for (int k = 1; k < tdpt_pkg::MAX_PERIODS; k++) v[k] = v[k-1] + $urandom_range(0, 25);
    end else if (shape == 4) begin
      if (n < 2) n = 2;
      j = $urandom_range(0, n - 2);
      v[j] = v[j+1] + $urandom_range(1, 500);
    end
    // entries past the count are ignored, so fill them with anything
    for (int k = n; k < tdpt_pkg::MAX_PERIODS; k++) v[k] = $urandom_range(0, 131071);
    for (int k = 0; k < tdpt_pkg::MAX_PERIODS; k++) starts[k] = tdpt_pkg::START_W'(v[k]);
    count = 3'(n);
    load_table(count, starts);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("time_of_day_period_tracker regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_took = in_tvalid && in_tready;
      out_took = out_tvalid && out_tready;
      if (out_took) begin
        got_r = tod_result_t'(out_tdata);
        if (pending_periods.size() == 0) begin
          $error("result transfer with nothing pending");
          mismatch_count++;
        end else begin
          exp_r = pending_periods.pop_front();
          results_checked++;
          if (got_r.changed !== exp_r.changed) begin
            $error("changed: expected %0d, got %0d", exp_r.changed, got_r.changed);
            mismatch_count++;
          end
          if (got_r.period_index !== exp_r.period_index) begin
            $error("period_index: expected %0d, got %0d",
                   exp_r.period_index, got_r.period_index);
            mismatch_count++;
          end
          if (got_r.period_start !== exp_r.period_start) begin
            $error("period_start: expected %0d, got %0d",
                   $signed(exp_r.period_start), $signed(got_r.period_start));
            mismatch_count++;
          end
          if (got_r.period_end !== exp_r.period_end) begin
            $error("period_end: expected %0d, got %0d", exp_r.period_end, got_r.period_end);
            mismatch_count++;
          end
          if (got_r.config_error !== exp_r.config_error) begin
            $error("config_error: expected %0d, got %0d",
                   exp_r.config_error, got_r.config_error);
            mismatch_count++;
          end
        end
      end
      if (in_took) begin
        exp_r = track_period(in_tdata);
        if (want_typed) exp_r = typed_want;
        if (exp_r.changed) change_count++;
        if (exp_r.config_error) unordered_count++;
        items_taken++;
        pending_periods.push_back(exp_r);
      end
      if (cfg_we) begin
        if (cfg_index == tdpt_pkg::REG_NUM_PERIODS) model_count = cfg_wdata[2:0];
        else model_starts[cfg_index - tdpt_pkg::REG_START_0] = cfg_wdata;
      end
    end
  end

  // result side: random stalls, plus a long hold now and then to back up the pipe
  initial begin
    int stall;
    int next_hold;
    next_hold = 300;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (results_checked >= next_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        next_hold += 600;
      end
      stall = idle_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(negedge clk); while (!out_took);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = tdpt_pkg::REG_NUM_PERIODS;
    cfg_wdata = '0;
    idle_on = 1'b1;
    model_count = 3'd1;
    model_starts = '0;
    have_period = 1'b0;
    cur_period = '0;
    period_open = 0;
    period_close = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset table: one period from second zero
    plan.push_back(known_row(40'd0, 1, 0, 0, 86400, 0));
    plan.push_back(known_row(40'd0, 0, 0, 0, 86400, 0));
    plan.push_back(known_row(40'd86400, 0, 0, 0, 86400, 0));
    plan.push_back(known_row(40'd86401, 1, 0, 86400, 172800, 0));
    plan.push_back(time_row(40'hFF_FFFF_FFFF));
    plan.push_back(time_row(40'd1));
    // four periods; the first item wraps back into the previous day
    plan.push_back(table_row(4, 3600, 21600, 43200, 64800, 86399, 0, 131071));
    plan.push_back(known_row(40'd3600, 1, 3, -21600, 3600, 0));
    plan.push_back(known_row(40'd3601, 1, 0, 3600, 21600, 0));
    plan.push_back(known_row(40'd21600, 0, 0, 3600, 21600, 0));
    plan.push_back(time_row(40'd86399));
    plan.push_back(time_row(40'hFF_FFFF_FFFF));
    plan.push_back(known_row(40'd21600, 1, 0, 3600, 21600, 0));
    // unordered starts: hold the stored period
    plan.push_back(table_row(3, 50000, 40000, 60000, 0, 0, 0, 0));
    plan.push_back(known_row(40'd100, 0, 0, 3600, 21600, 1));
    plan.push_back(known_row(40'hFF_FFFF_FFFF, 0, 0, 3600, 21600, 1));
    // zero count acts as one, start past the end of the day
    plan.push_back(table_row(0, 131071, 5, 5, 5, 5, 5, 5));
    plan.push_back(time_row(40'd5));
    plan.push_back(time_row(40'd200000));
    plan.push_back(table_row(7, 0, 1, 2, 3, 4, 5, 131071));
    plan.push_back(time_row(40'd1));
    plan.push_back(time_row(40'd6));
    plan.push_back(time_row(40'd86400));
    plan.push_back(time_row(40'hFF_FFFF_FFFF));
    // fewer periods than the stored index
    plan.push_back(table_row(2, 0, 43200, 131071, 131071, 131071, 131071, 131071));
    plan.push_back(time_row(40'd172800));
    plan.push_back(time_row(40'd172801));

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_TABLE) load_table(plan[r].count, plan[r].starts);
      else offer_time(plan[r].stamp, plan[r].typed, plan[r].want);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      load_random_table(phase);
      idle_on = (phase % 3 != 2);
      if ($urandom_range(0, 1) == 1) cursor = {$urandom, $urandom} & TIME_MASK;
      else cursor = $urandom_range(0, 3 * tdpt_pkg::SECS_PER_DAY);
      repeat (PHASE_ITEMS) offer_time(next_time(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_periods.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Covered %0d time stamps across %0d period tables; %0d results compared.",
             items_taken, table_loads, results_checked);
    $display("Of those, %0d reported a period change and %0d an unordered table.",
             change_count, unordered_count);
    if (mismatch_count == 0) begin
      $display("time_of_day_period_tracker regression: pass");
    end else begin
      $display("time_of_day_period_tracker regression: fail");
    end
    $finish;
  end

endmodule
